// ----- design/spf_pkg.sv -----
// Shared types, constants and byte selection for the servo packet framer.
// No dependencies; every other file depends on this package.
`timescale 1ns / 1ps

package spf_pkg;

	localparam logic [7:0] HDR_BYTE  = 8'hFF;
	localparam logic [7:0] INS_WRITE = 8'h03;
	localparam logic [7:0] INS_READ  = 8'h02;
	localparam logic [7:0] LEN_SHORT = 8'h04;
	localparam logic [7:0] LEN_LONG  = 8'h05;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [3:0] IDX_HDR0 = 4'd0;
	localparam logic [3:0] IDX_HDR1 = 4'd1;
	localparam logic [3:0] IDX_ID   = 4'd2;
	localparam logic [3:0] IDX_LEN  = 4'd3;
	localparam logic [3:0] IDX_INS  = 4'd4;
	localparam logic [3:0] IDX_REG  = 4'd5;
	localparam logic [3:0] IDX_P0   = 4'd6;
	localparam logic [3:0] IDX_P1   = 4'd7;
	localparam logic [3:0] IDX_END8 = 4'd7;
	localparam logic [3:0] IDX_END9 = 4'd8;

	typedef struct packed {
		logic        op;
		logic [7:0]  servo_id;
		logic [7:0]  reg_addr;
		logic [7:0]  byte_count;
		logic [15:0] write_data;
	} cmd_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
	} pkt_t;

	typedef struct packed {
		logic       is_read;
		logic       two;
		logic [7:0] id;
		logic [7:0] reg_addr;
		logic [7:0] p0;
		logic [7:0] p1;
		logic [7:0] chk;
	} desc_t;

	typedef struct packed {
		logic       busy;
		logic [3:0] idx;
	} bk_status_t;

	function automatic logic [3:0] last_idx(input desc_t d);
		return (!d.is_read && d.two) ? IDX_END9 : IDX_END8;
	endfunction

	function automatic logic [7:0] byte_at(input desc_t d, input logic [3:0] idx);
		logic [7:0] b;
		unique case (idx)
			IDX_HDR0: b = HDR_BYTE;
			IDX_HDR1: b = HDR_BYTE;
			IDX_ID:   b = d.id;
			IDX_LEN:  b = (!d.is_read && d.two) ? LEN_LONG : LEN_SHORT;
			IDX_INS:  b = d.is_read ? INS_READ : INS_WRITE;
			IDX_REG:  b = d.reg_addr;
			IDX_P0:   b = d.p0;
			IDX_P1:   b = (!d.is_read && d.two) ? d.p1 : d.chk;
			default:  b = d.chk;
		endcase
		return b;
	endfunction

endpackage

// ----- design/spf_cmd_if.sv -----
// Command channel: valid, ready and one command item.
// Depends on spf_pkg for the payload type.
`timescale 1ns / 1ps

interface spf_cmd_if;
	logic          valid;
	logic          ready;
	spf_pkg::cmd_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- design/spf_pkt_if.sv -----
// Packet byte channel: valid, ready and one byte item with its last mark.
// Depends on spf_pkg for the payload type.
`timescale 1ns / 1ps

interface spf_pkt_if;
	logic          valid;
	logic          ready;
	spf_pkg::pkt_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- design/spf_front.sv -----
// Front end: accepts commands, classifies them and computes the checksum.
// Depends on spf_pkg and spf_cmd_if.
`timescale 1ns / 1ps

module spf_front (
	input  logic            clk,
	input  logic            arst_n,
	spf_cmd_if.sink         cmd,
	output logic            push_valid,
	input  logic            push_ready,
	output spf_pkg::desc_t  push_data
);
	import spf_pkg::*;

	logic  v_s1;
	desc_t desc_s1;
	desc_t desc_c;
	logic [7:0] len_c;
	logic [7:0] ins_c;
	logic [7:0] sum_c;

	assign cmd.ready = !v_s1 || push_ready;

	always_comb begin
		desc_c.is_read  = cmd.data.op;
		desc_c.two      = (cmd.data.byte_count > 8'd1);
		desc_c.id       = cmd.data.servo_id;
		desc_c.reg_addr = cmd.data.reg_addr;
		desc_c.p0       = cmd.data.op ? cmd.data.byte_count : cmd.data.write_data[7:0];
		desc_c.p1       = (!cmd.data.op && desc_c.two) ? cmd.data.write_data[15:8] : 8'd0;
		len_c           = (!cmd.data.op && desc_c.two) ? LEN_LONG : LEN_SHORT;
		ins_c           = cmd.data.op ? INS_READ : INS_WRITE;
		sum_c           = desc_c.id + len_c + ins_c + desc_c.reg_addr + desc_c.p0 + desc_c.p1;
		desc_c.chk      = ~sum_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (cmd.ready) begin
			v_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			desc_s1 <= desc_c;
		end
	end

	assign push_valid = v_s1;
	assign push_data  = desc_s1;

endmodule

// ----- design/spf_queue.sv -----
// Short queue of classified packets between front end and serializer.
// Depends on spf_pkg.
`timescale 1ns / 1ps

module spf_queue #(
	parameter int DEPTH = spf_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  spf_pkg::desc_t  push_data,
	output logic            pop_valid,
	input  logic            pop_ready,
	output spf_pkg::desc_t  pop_data
);
	import spf_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	desc_t         mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (count_q != FULL_CNT);
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ----- design/spf_back.sv -----
// Serializer: walks one packet a byte per cycle into an output register while pkt.ready does not hold it.
// Depends on spf_pkg and spf_pkt_if.
`timescale 1ns / 1ps

module spf_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pop_valid,
	output logic                pop_ready,
	input  spf_pkg::desc_t      pop_data,
	spf_pkt_if.source           pkt,
	output spf_pkg::bk_status_t status
);
	import spf_pkg::*;

	desc_t      cur_q;
	logic       busy_q;
	logic [3:0] idx_q;
	logic       out_v_q;
	pkt_t       out_q;
	logic       adv;
	logic       at_end;
	logic       reload;

	assign adv       = !out_v_q || pkt.ready;
	assign at_end    = busy_q && (idx_q == last_idx(cur_q));
	assign reload    = adv && (!busy_q || at_end);
	assign pop_ready = reload;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			busy_q  <= 1'b0;
			idx_q   <= '0;
		end else if (adv) begin
			out_v_q <= busy_q;
			if (reload) begin
				busy_q <= pop_valid;
				idx_q  <= '0;
			end else begin
				idx_q  <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.out_byte <= byte_at(cur_q, idx_q);
			out_q.last     <= at_end;
		end
		if (reload && pop_valid) begin
			cur_q <= pop_data;
		end
	end

	assign pkt.valid   = out_v_q;
	assign pkt.data    = out_q;
	assign status.busy = busy_q;
	assign status.idx  = idx_q;

endmodule

// ----- design/servo_packet_framer_core.sv -----
// Servo instruction packet framer, top level.
// Depends on spf_pkg, spf_cmd_if, spf_pkt_if, spf_front, spf_queue, spf_back.
//
// Takes one write or read command per item and sends the complete instruction
// packet as byte items, the checksum byte marked last. A packet has nine bytes
// for a write with a count above one, eight for any other command, one byte
// per cycle from the serializer while the output ready does not hold it. Under
// steady traffic the packets follow each other with no gap; commands are
// accepted while a packet is being sent, with up to QUEUE_DEPTH classified
// commands plus one in the front register waiting behind it. From idle, a
// command's first byte follows the front, queue and serializer registers.
`timescale 1ns / 1ps

module servo_packet_framer_core #(
	parameter int QUEUE_DEPTH = spf_pkg::QUEUE_DEPTH
) (
	input  logic    clk,
	input  logic    arst_n,
	spf_cmd_if.sink cmd,
	spf_pkt_if.source pkt
);
	import spf_pkg::*;

	logic       push_valid;
	logic       push_ready;
	desc_t      push_data;
	logic       pop_valid;
	logic       pop_ready;
	desc_t      pop_data;
	bk_status_t status;

	spf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	spf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	spf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.pkt       (pkt),
		.status    (status)
	);

	a_front_hold: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid && !push_ready |=> push_valid && $stable(push_data))
		else $error("front register lost a command while the queue was full");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		status.busy |-> status.idx <= IDX_END9)
		else $error("serializer index ran past the end of a packet");

	a_last_restart: assert property (@(posedge clk) disable iff (!arst_n)
		pkt.valid && pkt.ready && pkt.data.last |=> !(status.busy && status.idx > IDX_HDR1))
		else $error("serializer did not restart after the checksum byte");

	a_hdr_after_gap: assert property (@(posedge clk) disable iff (!arst_n)
		pkt.valid && !status.busy |-> pkt.data.last || !pop_ready)
		else $error("serializer went idle in the middle of a packet");

endmodule
